// ===== hdl/crcfc_pkg.sv =====
// Shared widths, codes, types and the CRC-16/MODBUS byte update for the frame checker.
package crcfc_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CRC_W       = 16;

    localparam int MAX_PAYLOAD_DEFAULT = 64;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TAIL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CRC    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_BYTE      = 2'd2;

    localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RESET = 7'd8;
    localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET    = 8'hA5;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RESET      = 8'h5A;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Frame judgment handed from the parser to the replay sequencer.
    typedef struct packed {
        logic                valid;
        logic                good;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   command;
    } verdict_t;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcfc_ifs.sv =====
// Valid/ready channel interfaces: received bytes, frame results and register writes.
interface crcfc_in_if import crcfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface crcfc_out_if import crcfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   command;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last;

    modport source (output valid, output status, output command, output payload_byte,
                    output last, input ready);
    modport sink   (input valid, input status, input command, input payload_byte,
                    input last, output ready);
endinterface

interface crcfc_cfg_if import crcfc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/crcfc_payload_ram.sv =====
// Payload byte store: one write port, one read port with registered read data.
module crcfc_payload_ram import crcfc_pkg::*;
#(
    parameter int DEPTH  = MAX_PAYLOAD_DEFAULT,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/crcfc_parser.sv =====
// Frame parser: byte position, running CRC, header check, payload writes and the verdict.
module crcfc_parser import crcfc_pkg::*;
#(
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              frame_start,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic [BYTE_W-1:0] header_byte,
    input  logic [BYTE_W-1:0] tail_byte,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output verdict_t          verdict
);

    logic [LEN_W-1:0]  pos_reg,        pos_next;
    logic [CRC_W-1:0]  crc_reg,        crc_next;
    logic              header_bad_reg, header_bad_next;
    logic [BYTE_W-1:0] cmd_reg,        cmd_next;
    logic [BYTE_W-1:0] crc_low_reg,    crc_low_next;

    logic [LEN_W-1:0]  pos_cur;
    logic [LEN_W-1:0]  crc_low_pos;
    logic [LEN_W-1:0]  crc_high_pos;
    logic [LEN_W-1:0]  slot;
    logic [CRC_W-1:0]  crc_step;

    assign pos_cur      = frame_start ? '0 : pos_reg;
    assign crc_low_pos  = payload_len + LEN_W'(2);
    assign crc_high_pos = payload_len + LEN_W'(3);
    assign slot         = pos_cur - LEN_W'(2);
    assign crc_step     = crc16_update(crc_reg, rx_byte);

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        header_bad_next = header_bad_reg;
        cmd_next        = cmd_reg;
        crc_low_next    = crc_low_reg;
        wr_en           = 1'b0;
        wr_addr         = slot[ADDR_W-1:0];
        wr_data         = rx_byte;
        verdict.valid   = 1'b0;
        verdict.good    = 1'b0;
        verdict.status  = STATUS_OK;
        verdict.command = cmd_reg;

        if (fire)
        begin
            pos_next = pos_cur + LEN_W'(1);
            if (pos_cur == '0)
            begin
                header_bad_next = (rx_byte != header_byte);
                crc_next        = CRC_INIT;
            end
            else if (pos_cur == LEN_W'(1))
            begin
                cmd_next = rx_byte;
                crc_next = crc_step;
            end
            else if (pos_cur < crc_low_pos)
            begin
                wr_en    = 1'b1;
                crc_next = crc_step;
            end
            else if (pos_cur == crc_low_pos)
            begin
                crc_low_next = rx_byte;
            end
            else if (pos_cur == crc_high_pos)
            begin
                // fold received CRC in: zero means match
                crc_next = crc_reg ^ {rx_byte, crc_low_reg};
            end
            else
            begin
                pos_next      = '0;
                verdict.valid = 1'b1;
                if (header_bad_reg)
                begin
                    verdict.status = STATUS_BAD_HEADER;
                end
                else if (rx_byte != tail_byte)
                begin
                    verdict.status = STATUS_BAD_TAIL;
                end
                else if (crc_reg != '0)
                begin
                    verdict.status = STATUS_BAD_CRC;
                end
                else
                begin
                    verdict.good = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= CRC_INIT;
            header_bad_reg <= 1'b0;
            cmd_reg        <= '0;
            crc_low_reg    <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            header_bad_reg <= header_bad_next;
            cmd_reg        <= cmd_next;
            crc_low_reg    <= crc_low_next;
        end
    end

endmodule

// ===== hdl/crcfc_replay.sv =====
// Result sequencer: error items and payload replay from the RAM into the output register.
module crcfc_replay import crcfc_pkg::*;
#(
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  verdict_t          verdict,
    input  logic [LEN_W-1:0]  payload_len,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              can_take,
    crcfc_out_if.source       dout
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEND = 2'd1;

    logic [1:0]          state_reg,      state_next;
    logic [ADDR_W-1:0]   idx_reg,        idx_next;
    logic [LEN_W-1:0]    len_reg,        len_next;
    logic [BYTE_W-1:0]   cmd_reg,        cmd_next;
    logic                out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_cmd_reg,    out_cmd_next;
    logic [BYTE_W-1:0]   out_byte_reg,   out_byte_next;
    logic                out_last_reg,   out_last_next;

    logic slot_free;
    logic last_item;
    logic load;

    assign slot_free = !out_valid_reg || dout.ready;
    assign can_take  = (state_reg == ST_IDLE) && slot_free;
    assign last_item = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;
    assign load      = (state_reg == ST_SEND) && slot_free;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        cmd_next        = cmd_reg;
        out_valid_next  = out_valid_reg && !dout.ready;
        out_status_next = out_status_reg;
        out_cmd_next    = out_cmd_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (verdict.valid && verdict.good)
                begin
                    // issue the first read; data lands next cycle
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    len_next   = payload_len;
                    cmd_next   = verdict.command;
                    state_next = ST_SEND;
                end
                else if (verdict.valid)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = verdict.status;
                    out_cmd_next    = verdict.command;
                    out_byte_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
            ST_SEND:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_cmd_next    = cmd_reg;
                    out_byte_next   = rd_data;
                    out_last_next   = last_item;
                    if (last_item)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        len_reg        <= len_next;
        cmd_reg        <= cmd_next;
        out_status_reg <= out_status_next;
        out_cmd_reg    <= out_cmd_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    assign dout.valid        = out_valid_reg;
    assign dout.status       = out_status_reg;
    assign dout.command      = out_cmd_reg;
    assign dout.payload_byte = out_byte_reg;
    assign dout.last         = out_last_reg;

    a_verdict_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (state_reg == ST_IDLE) && slot_free)
        else $error("verdict arrived while the sequencer was busy or the output was full");

    a_read_source: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ST_SEND) || (verdict.valid && verdict.good))
        else $error("RAM read issued outside a replay");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_OK) |-> out_last_reg && out_byte_reg == '0)
        else $error("error item without last mark or with nonzero payload");

    a_replay_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_item) |=> (state_reg == ST_IDLE) && out_valid_reg && out_last_reg)
        else $error("replay did not end on its last item");

endmodule

// ===== hdl/crc16_frame_checker.sv =====
// Top level of the CRC-16/MODBUS frame checker: configuration registers and block wiring.
// While a frame is received the block takes one byte per cycle unless input is held off;
// positions, the running CRC and the header check advance on each byte and payload bytes
// go into a payload RAM with one write and one read port. At the tail byte an error result
// is loaded into the output register at that byte's own clock edge, while a good frame is
// replayed from the RAM through its one read port, and input is held off until the replay
// has loaded its last item. Input is also held off while the output register holds an
// item that is not being taken. Results leave through one output register. The payload
// RAM needs no clearing after reset.
module crc16_frame_checker import crcfc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    crcfc_in_if.sink    din,
    crcfc_out_if.source dout,
    crcfc_cfg_if.sink   cfg
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic [LEN_W-1:0]  len_cfg_reg;
    logic [BYTE_W-1:0] header_cfg_reg;
    logic [BYTE_W-1:0] tail_cfg_reg;
    logic [LEN_W-1:0]  payload_len;

    logic              fire;
    logic              can_take;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    verdict_t          verdict;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg    <= PAYLOAD_LENGTH_RESET;
            header_cfg_reg <= HEADER_BYTE_RESET;
            tail_cfg_reg   <= TAIL_BYTE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PAYLOAD_LENGTH: len_cfg_reg    <= cfg.data[LEN_W-1:0];
                REG_HEADER_BYTE:    header_cfg_reg <= cfg.data;
                REG_TAIL_BYTE:      tail_cfg_reg   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // Clamp the length into 1..MAX_PAYLOAD.
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            payload_len = LEN_W'(1);
        end
        else if (len_cfg_reg > MAX_LEN)
        begin
            payload_len = MAX_LEN;
        end
        else
        begin
            payload_len = len_cfg_reg;
        end
    end

    assign din.ready = can_take;
    assign fire      = din.valid && can_take;

    crcfc_parser #(
        .ADDR_W (ADDR_W)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .rx_byte     (din.rx_byte),
        .frame_start (din.frame_start),
        .payload_len (payload_len),
        .header_byte (header_cfg_reg),
        .tail_byte   (tail_cfg_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .verdict     (verdict)
    );

    crcfc_payload_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crcfc_replay #(
        .ADDR_W (ADDR_W)
    ) u_replay (
        .clk         (clk),
        .rst_n       (rst_n),
        .verdict     (verdict),
        .payload_len (payload_len),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .can_take    (can_take),
        .dout        (dout)
    );

endmodule
